FILE: src/qeit_pkg.sv
// Package: widths, types and helpers shared by the edge intersection test unit.
`default_nettype none
package qeit_pkg;
	localparam int CoordWidth = 16;
	localparam int DiffWidth  = CoordWidth + 1;
	localparam int ProdWidth  = 2 * DiffWidth;
	localparam int WideWidth  = ProdWidth + 1;
	localparam int NumLanes   = 4;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [DiffWidth-1:0]  diff_t;
	typedef logic signed [ProdWidth-1:0]  prod_t;
	typedef logic signed [WideWidth-1:0]  wide_t;

	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		coord_t x3;
		coord_t y3;
		coord_t x4;
		coord_t y4;
	} pair_t;

	function automatic logic range_touch(coord_t a1, coord_t a2, coord_t b1, coord_t b2);
		coord_t amax;
		coord_t amin;
		coord_t bmax;
		coord_t bmin;
		amax = (a1 > a2) ? a1 : a2;
		amin = (a1 < a2) ? a1 : a2;
		bmax = (b1 > b2) ? b1 : b2;
		bmin = (b1 < b2) ? b1 : b2;
		return !(((a1 < b1) && (amax < bmin)) || ((b1 < a1) && (bmax < amin)));
	endfunction

	function automatic logic inside_unit(wide_t num, wide_t den);
		if (num == '0 || num[WideWidth-1] != den[WideWidth-1]) begin
			return 1'b0;
		end
		return den[WideWidth-1] ? (den < num) : (num < den);
	endfunction
endpackage
`default_nettype wire

FILE: src/qeit_lane.sv
// One segment-pair tester lane, two pipeline stages.
`default_nettype none
module qeit_lane (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  qeit_pkg::pair_t  pair,
	output logic             done,
	output logic             hit
);
	qeit_pkg::prod_t p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	qeit_pkg::pair_t pair_s1;
	logic            vld_s1;
	qeit_pkg::diff_t dxa, dya, dxb, dyb, ox, oy;
	qeit_pkg::wide_t den, na, nb;
	logic            par_hit;

	always_comb begin
		dxa = qeit_pkg::diff_t'(pair.x2) - qeit_pkg::diff_t'(pair.x1);
		dya = qeit_pkg::diff_t'(pair.y2) - qeit_pkg::diff_t'(pair.y1);
		dxb = qeit_pkg::diff_t'(pair.x4) - qeit_pkg::diff_t'(pair.x3);
		dyb = qeit_pkg::diff_t'(pair.y4) - qeit_pkg::diff_t'(pair.y3);
		ox  = qeit_pkg::diff_t'(pair.x1) - qeit_pkg::diff_t'(pair.x3);
		oy  = qeit_pkg::diff_t'(pair.y1) - qeit_pkg::diff_t'(pair.y3);
	end

	always_ff @(posedge clk) begin
		p0_s1   <= dyb * dxa;
		p1_s1   <= dxb * dya;
		p2_s1   <= dxb * oy;
		p3_s1   <= dyb * ox;
		p4_s1   <= dxa * oy;
		p5_s1   <= dya * ox;
		pair_s1 <= pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			done   <= vld_s1;
		end
	end

	always_comb begin
		den = qeit_pkg::wide_t'(p0_s1) - qeit_pkg::wide_t'(p1_s1);
		na  = qeit_pkg::wide_t'(p2_s1) - qeit_pkg::wide_t'(p3_s1);
		nb  = qeit_pkg::wide_t'(p4_s1) - qeit_pkg::wide_t'(p5_s1);
		if (pair_s1.x1 == pair_s1.x2) begin
			par_hit = qeit_pkg::range_touch(pair_s1.y1, pair_s1.y2, pair_s1.y3, pair_s1.y4);
		end else begin
			par_hit = qeit_pkg::range_touch(pair_s1.x1, pair_s1.x2, pair_s1.x3, pair_s1.x4);
		end
	end

	always_ff @(posedge clk) begin
		if (den == '0) begin
			hit <= (na == '0) && par_hit;
		end else begin
			hit <= qeit_pkg::inside_unit(na, den) && qeit_pkg::inside_unit(nb, den);
		end
	end
endmodule
`default_nettype wire

FILE: src/quad_edge_intersection_test_unit.sv
// Top level: corner store, four tester lanes and the merging OR.
// Corner 0..2 requests are only stored and give no result. A corner 3
// request sweeps the four first-quad edges, one per cycle, each against all four
// second-quad edges in four two-stage lanes; the merged flag is held until taken.
// A corner 3 request holds the input until its flag has been taken: s_tready stays
// low while busy or while the flag waits. Reset clears control only.
`default_nettype none
module quad_edge_intersection_test_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// tdata: corner_index[1:0], first_x, first_y, second_x, second_y, 6 zero bits
	input  wire  [71:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// tdata: overlap[0], 7 zero bits
	output logic [7:0]  m_tdata
);
	localparam int W = qeit_pkg::CoordWidth;

	qeit_pkg::coord_t fx_q [4];
	qeit_pkg::coord_t fy_q [4];
	qeit_pkg::coord_t sx_q [4];
	qeit_pkg::coord_t sy_q [4];

	logic        busy_q;
	logic [2:0]  cnt_q;      // edges issued so far
	logic        acc_q;
	logic [2:0]  seen_q;     // lane results merged
	logic        ovl_q;

	logic [1:0]  ci;
	logic        acc_fire;
	logic        issue;
	logic [1:0]  e, en;
	logic [3:0]  ldone, lhit;
	qeit_pkg::pair_t lp [4];

	assign ci       = s_tdata[1:0];
	assign s_tready = !busy_q && !m_tvalid;
	assign acc_fire = s_tvalid && s_tready;
	assign issue    = busy_q && !cnt_q[2];
	assign e        = cnt_q[1:0];
	assign en       = e + 2'd1;
	assign m_tdata  = {7'd0, ovl_q};

	// store the corner of both quads
	always_ff @(posedge clk) begin
		if (acc_fire) begin
			fx_q[ci] <= s_tdata[2 +: W];
			fy_q[ci] <= s_tdata[2 + W +: W];
			sx_q[ci] <= s_tdata[2 + 2*W +: W];
			sy_q[ci] <= s_tdata[2 + 3*W +: W];
		end
	end

	for (genvar j = 0; j < qeit_pkg::NumLanes; j++) begin : g_lane
		localparam logic [1:0] J  = 2'(j);
		localparam logic [1:0] JN = 2'(j + 1);
		always_comb begin
			lp[j].x1 = fx_q[e];
			lp[j].y1 = fy_q[e];
			lp[j].x2 = fx_q[en];
			lp[j].y2 = fy_q[en];
			lp[j].x3 = sx_q[J];
			lp[j].y3 = sy_q[J];
			lp[j].x4 = sx_q[JN];
			lp[j].y4 = sy_q[JN];
		end
		qeit_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (issue),
			.pair   (lp[j]),
			.done   (ldone[j]),
			.hit    (lhit[j])
		);
	end

	// sweep edges, merge lane flags, hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			acc_q    <= 1'b0;
			seen_q   <= '0;
			m_tvalid <= 1'b0;
			ovl_q    <= 1'b0;
		end else begin
			if (acc_fire && ci == 2'd3) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= 1'b0;
				seen_q <= '0;
			end
			if (issue) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (busy_q && ldone[0]) begin
				seen_q <= seen_q + 3'd1;
				acc_q  <= acc_q | (|lhit);
				if (seen_q == 3'd3) begin
					busy_q   <= 1'b0;
					m_tvalid <= 1'b1;
					ovl_q    <= acc_q | (|lhit);
				end
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/qeit_checker.sv
// Port-level checker for the edge intersection test unit, with its bind.
`default_nettype none
module qeit_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [71:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [7:0]  m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("pad bits set");
	a_noready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while result waits");
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[1:0] == 2'd3 |=> !s_tready)
		else $error("request taken during test");
endmodule

bind quad_edge_intersection_test_unit qeit_checker u_chk (.*);
`default_nettype wire

FILE: dv/quad_edge_intersection_test_unit_test.sv
// Testbench: quad edge intersection test unit, table-driven and random requests.
`default_nettype none
module quad_edge_intersection_test_unit_test;

	// One request: the corner slot and one corner of each quad.
	typedef struct {
		logic [1:0]       corner;
		qeit_pkg::coord_t ax;
		qeit_pkg::coord_t ay;
		qeit_pkg::coord_t bx;
		qeit_pkg::coord_t by;
		int               want;   // -1: use the predictor, else the typed-in overlap flag
	} corner_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	quad_edge_intersection_test_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Local copy of the four stored corners of each quad.
	qeit_pkg::coord_t quad_ax[4];
	qeit_pkg::coord_t quad_ay[4];
	qeit_pkg::coord_t quad_bx[4];
	qeit_pkg::coord_t quad_by[4];

	logic pending_overlap[$];
	int   fail_count;
	int   flag_count;
	int   hit_count;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   hold_off;
	bit   stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Exact product of two differences, widened to the compare width.
	function automatic qeit_pkg::wide_t mul_wide(qeit_pkg::diff_t a, qeit_pkg::diff_t b);
		qeit_pkg::prod_t p;
		p = a * b;
		return qeit_pkg::wide_t'(p);
	endfunction

	// Check num/den strictly inside the open unit interval.
	function automatic logic frac_in_unit(qeit_pkg::wide_t num, qeit_pkg::wide_t den);
		if (num == 0 || ((num < 0) != (den < 0))) begin
			return 1'b0;
		end
		return (den < 0) ? (num > den) : (num < den);
	endfunction

	function automatic logic spans_touch(qeit_pkg::coord_t a1, qeit_pkg::coord_t a2,
			qeit_pkg::coord_t b1, qeit_pkg::coord_t b2);
		qeit_pkg::coord_t amax;
		qeit_pkg::coord_t amin;
		qeit_pkg::coord_t bmax;
		qeit_pkg::coord_t bmin;
		amax = (a1 > a2) ? a1 : a2;
		amin = (a1 < a2) ? a1 : a2;
		bmax = (b1 > b2) ? b1 : b2;
		bmin = (b1 < b2) ? b1 : b2;
		return !(((a1 < b1) && (amax < bmin)) || ((b1 < a1) && (bmax < amin)));
	endfunction

	function automatic logic edges_meet(qeit_pkg::coord_t x1, qeit_pkg::coord_t y1,
			qeit_pkg::coord_t x2, qeit_pkg::coord_t y2,
			qeit_pkg::coord_t x3, qeit_pkg::coord_t y3,
			qeit_pkg::coord_t x4, qeit_pkg::coord_t y4);
		qeit_pkg::diff_t dxa;
		qeit_pkg::diff_t dya;
		qeit_pkg::diff_t dxb;
		qeit_pkg::diff_t dyb;
		qeit_pkg::diff_t ox;
		qeit_pkg::diff_t oy;
		qeit_pkg::wide_t den;
		qeit_pkg::wide_t na;
		qeit_pkg::wide_t nb;
		dxa = qeit_pkg::diff_t'(x2) - qeit_pkg::diff_t'(x1);
		dya = qeit_pkg::diff_t'(y2) - qeit_pkg::diff_t'(y1);
		dxb = qeit_pkg::diff_t'(x4) - qeit_pkg::diff_t'(x3);
		dyb = qeit_pkg::diff_t'(y4) - qeit_pkg::diff_t'(y3);
		ox  = qeit_pkg::diff_t'(x1) - qeit_pkg::diff_t'(x3);
		oy  = qeit_pkg::diff_t'(y1) - qeit_pkg::diff_t'(y3);
		den = mul_wide(dyb, dxa) - mul_wide(dxb, dya);
		na  = mul_wide(dxb, oy) - mul_wide(dyb, ox);
		nb  = mul_wide(dxa, oy) - mul_wide(dya, ox);
		if (den == 0) begin
			// parallel: only coincident edges count, by span overlap
			if (na != 0) begin
				return 1'b0;
			end
			if (x1 == x2) begin
				return spans_touch(y1, y2, y3, y4);
			end
			return spans_touch(x1, x2, x3, x4);
		end
		return frac_in_unit(na, den) && frac_in_unit(nb, den);
	endfunction

	// Store the corner; on corner 3 predict the overlap flag.
	function automatic int predict_overlap(corner_req_t r);
		logic hit;
		int ni;
		int nj;
		quad_ax[r.corner] = r.ax;
		quad_ay[r.corner] = r.ay;
		quad_bx[r.corner] = r.bx;
		quad_by[r.corner] = r.by;
		if (r.corner != 2'd3) begin
			return -1;
		end
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			ni = (i + 1) % 4;
			for (int j = 0; j < 4; j++) begin
				nj = (j + 1) % 4;
				if (edges_meet(quad_ax[i], quad_ay[i], quad_ax[ni], quad_ay[ni],
						quad_bx[j], quad_by[j], quad_bx[nj], quad_by[nj])) begin
					hit = 1'b1;
				end
			end
		end
		return int'(hit);
	endfunction

	// Drive one request and hold it until accepted; queue its expected flag.
	// Leave tvalid high on return: the caller drives the next request or drops it.
	task automatic send_request(corner_req_t r);
		int exp_flag;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, r.by, r.bx, r.ay, r.ax, r.corner};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		exp_flag = predict_overlap(r);
		if (exp_flag >= 0) begin
			if (r.want >= 0 && r.want != exp_flag) begin
				$error("table row disagrees with predictor: overlap expected %0d, got %0d",
					r.want, exp_flag);
				fail_count++;
			end
			pending_overlap.push_back(exp_flag[0]);
			flag_count++;
			hit_count += exp_flag;
		end
	endtask

	function automatic qeit_pkg::coord_t rand_coord(int mode);
		case (mode)
			0: return qeit_pkg::coord_t'($urandom);
			1: return qeit_pkg::coord_t'($urandom_range(20) - 10);
			2: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
			default: return qeit_pkg::coord_t'($urandom_range(4000) - 2000);
		endcase
	endfunction

	// Send a whole quad pair: corners 0..3 with shared coordinate style.
	task automatic send_quad_pair(int mode);
		corner_req_t r;
		for (int c = 0; c < 4; c++) begin
			r.corner = c[1:0];
			r.ax = rand_coord(mode);
			r.ay = rand_coord(mode);
			r.bx = rand_coord(mode);
			r.by = rand_coord(mode);
			r.want = -1;
			// share edges now and then to reach the parallel rule
			if (mode == 1 && $urandom_range(3) == 0) begin
				r.bx = r.ax;
				r.by = r.ay;
			end
			send_request(r);
		end
	endtask

	// Drop m_tready at random; honor the long hold-off.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare every accepted flag against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_overlap.size() == 0) begin
				$error("unexpected result: overlap %0d", m_tdata[0]);
				fail_count++;
			end else begin
				logic exp_bit;
				exp_bit = pending_overlap.pop_front();
				if (m_tdata[0] !== exp_bit) begin
					$error("overlap mismatch: expected %0d, actual %0d", exp_bit, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[7:1] !== 7'd0) begin
					$error("pad mismatch: expected 0, actual %0h", m_tdata[7:1]);
					fail_count++;
				end
			end
		end
	end

	localparam qeit_pkg::coord_t CMax = 16'sh7fff;
	localparam qeit_pkg::coord_t CMin = 16'sh8000;

	// Directed table: extremes, crossing, touching, parallel and degenerate edges.
	corner_req_t direct_rows[] = '{
		// crossing squares offset by half a side
		'{2'd0, 16'sd0,  16'sd0,  16'sd5,  16'sd5,  -1},
		'{2'd1, 16'sd10, 16'sd0,  16'sd15, 16'sd5,  -1},
		'{2'd2, 16'sd10, 16'sd10, 16'sd15, 16'sd15, -1},
		'{2'd3, 16'sd0,  16'sd10, 16'sd5,  16'sd15, 1},
		// corners 0 and 3 moved far out, corners 1 and 2 kept
		'{2'd0, 16'sd100, 16'sd100, -16'sd100, -16'sd100, -1},
		'{2'd3, 16'sd100, 16'sd110, -16'sd100, -16'sd110, -1},
		// all corners at zero: degenerate, coincident
		'{2'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -1},
		'{2'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -1},
		'{2'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -1},
		'{2'd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1},
		// extremes of the coordinate range
		'{2'd0, CMin, CMin, CMax, CMin, -1},
		'{2'd1, CMax, CMin, CMin, CMin, -1},
		'{2'd2, CMax, CMax, CMin, CMax, -1},
		'{2'd3, CMin, CMax, CMax, CMax, -1},
		'{2'd0, CMin, CMin, CMax, CMax, -1},
		'{2'd1, CMax, CMax, CMin, CMin, -1},
		'{2'd2, CMin, CMax, CMax, CMin, -1},
		'{2'd3, CMax, CMin, CMin, CMax, -1},
		// collinear horizontal and vertical edges, touching and apart
		'{2'd0, 16'sd0, 16'sd0, 16'sd5,  16'sd0, -1},
		'{2'd1, 16'sd4, 16'sd0, 16'sd9,  16'sd0, -1},
		'{2'd2, 16'sd4, 16'sd0, 16'sd9,  16'sd0, -1},
		'{2'd3, 16'sd0, 16'sd0, 16'sd5,  16'sd0, -1},
		'{2'd0, 16'sd0, 16'sd0, 16'sd0,  16'sd7, -1},
		'{2'd3, 16'sd0, 16'sd3, 16'sd0,  16'sd9, -1}
	};

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		fail_count     = 0;
		flag_count     = 0;
		hit_count      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off       = 0;
		stim_done      = 1'b0;
		for (int k = 0; k < 4; k++) begin
			quad_ax[k] = '0; quad_ay[k] = '0; quad_bx[k] = '0; quad_by[k] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (direct_rows[n]) begin
			send_request(direct_rows[n]);
		end

		// Random quad pairs over idling phases: none, sender, receiver, both, long receiver hold-off.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 300; end
			endcase
			for (int q = 0; q < 76; q++) begin
				if ($urandom_range(9) == 0) begin
					// lone corner rewrite between pairs, no result
					corner_req_t r;
					r.corner = 2'($urandom_range(2));
					r.ax = rand_coord(0); r.ay = rand_coord(0);
					r.bx = rand_coord(0); r.by = rand_coord(0);
					r.want = -1;
					send_request(r);
				end
				send_quad_pair($urandom_range(3));
			end
		end
		s_tvalid  <= 1'b0;
		stim_done = 1'b1;

		while (pending_overlap.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		$display("Covered %0d overlap tests (%0d hits) over five idling phases.",
			flag_count, hit_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
